### src/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package deq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_NONE       = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [CNT_W-1:0]   entry_count;
      logic               is_empty;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;   // apply the accepted operation and write the store
      logic load;   // read the store into the result register
   } deq_cmd_type;

endpackage

`default_nettype wire

### src/deq_ctrl.sv
// Sequencer for the double-ended queue unit: execute, then read out.
// Depends on deq_pkg.
`default_nettype none

module deq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output deq_pkg::deq_cmd_type    cmd
);
   import deq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, load;

   assign req_stall = (state_ff == ST_READ);
   assign accept    = req_valid && !req_stall;
   // The result register is free once its current transfer completes
   assign load      = (state_ff == ST_READ) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign cmd.exec  = accept;
   assign cmd.load  = load;

endmodule

`default_nettype wire

### src/deq_dpath.sv
// Datapath of the double-ended queue unit: pointers, count, value store
// and result register. Depends on deq_pkg.
`default_nettype none

module deq_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire deq_pkg::deq_cmd_type  cmd,
   input  wire deq_pkg::req_type      req_data,
   output deq_pkg::rsp_type           rsp_data
);
   import deq_pkg::*;

   logic [31:0]      mem [CAPACITY];

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       status_ff, status_in;
   rsp_type          rsp_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             full, empty;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
   endfunction

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      unique case (req_data.operation) inside
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (empty) begin
                  // first value sits where the front already points
                  back_in = front_ff;
                  wr_addr = front_ff;
               end else if (req_data.operation == OP_PUSH_FRONT) begin
                  front_in = idx_prev(front_ff);
                  wr_addr  = idx_prev(front_ff);
               end else begin
                  back_in = idx_next(back_ff);
                  wr_addr = idx_next(back_ff);
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               // popping the last value keeps both pointers
               if (count_ff != CNT_W'(1)) begin
                  if (req_data.operation == OP_POP_FRONT) begin
                     front_in = idx_next(front_ff);
                  end else begin
                     back_in = idx_prev(back_ff);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[wr_addr] <= req_data.push_value;
   end

   // Read both ends in the read-out state, after the write has landed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.front_value <= empty ? -32'sd1 : mem[front_ff];
         rsp_ff.back_value  <= empty ? -32'sd1 : mem[back_ff];
         rsp_ff.entry_count <= count_ff;
         rsp_ff.is_empty    <= empty;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

### src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// Bounded double-ended queue of 16 signed 32-bit values. Each request
// carries one operation (push back, push front, pop front, pop back or
// none) and yields exactly one response with the status, the front and
// back values (-1 when empty), the count and an empty flag. A request
// first updates the pointers and writes the store, then reads both ends
// from the store into the response register once that register is free.
// A new request is taken in the cycle after a response is loaded, even
// while that response is still stalled.
`default_nettype none

module double_ended_queue_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire deq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output deq_pkg::rsp_type       rsp_data
);
   import deq_pkg::*;

   deq_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   deq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
